/* design/mpe_pkg.sv */
// ----------------------------------------------------------------------------
// mpe_pkg: shared types and constants for the matrix product element
// Holds the field widths, operation and register codes, the controller
// state type and the command and status bundles between the modules.
// ----------------------------------------------------------------------------
package mpe_pkg;

    // Field widths of the stream words.
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 8;
    localparam int OP_W    = 2;
    localparam int DIM_W   = 5;
    // Width used for range checks against the store depth.
    localparam int CHK_W   = 16;
    // Width of the row base (quotient times inner length).
    localparam int BASE_W  = IDX_W + DIM_W;
    // Width of the divider step counter.
    localparam int DIVC_W  = $clog2(IDX_W);

    // Operation codes carried in the input word's user field.
    localparam logic [OP_W-1:0] OP_WRITE_LEFT  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_RIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY       = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_INNER_LEN = 1'b0;
    localparam logic REG_OUT_COLS  = 1'b1;

    // Reset value of both dimension registers.
    localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_BASE,
        ST_TEST,
        ST_MAC,
        ST_DRAIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write_left;
        logic write_right;
        logic start;
        logic div_step;
        logic base;
        logic test;
        logic issue;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
        logic range_err;
        logic issue_last;
        logic pipe_busy;
        logic out_free;
    } ctrl_status_t;

endpackage

/* design/mpe_regs.sv */
// ----------------------------------------------------------------------------
// mpe_regs: configuration registers
// APB-style access to the inner length and output column registers, and
// the clamped dimensions that the datapath works with.
// ----------------------------------------------------------------------------
module mpe_regs #(
    parameter int MAX_DIM = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [mpe_pkg::DIM_W-1:0]     inner_dim,
    output logic [mpe_pkg::DIM_W-1:0]     cols_dim
);

    logic [mpe_pkg::DIM_W-1:0] inner_len_reg, inner_len_next;
    logic [mpe_pkg::DIM_W-1:0] out_cols_reg,  out_cols_next;
    logic                      wr_en;
    logic                      reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel & penable & pwrite & pready;

    // Register write decode.
    always_comb begin
        inner_len_next = inner_len_reg;
        out_cols_next  = out_cols_reg;
        if (wr_en) begin
            case (reg_sel)
                mpe_pkg::REG_INNER_LEN: inner_len_next = pwdata[mpe_pkg::DIM_W-1:0];
                mpe_pkg::REG_OUT_COLS:  out_cols_next  = pwdata[mpe_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inner_len_reg <= mpe_pkg::DIM_RESET;
            out_cols_reg  <= mpe_pkg::DIM_RESET;
        end else begin
            inner_len_reg <= inner_len_next;
            out_cols_reg  <= out_cols_next;
        end
    end

    // Read back the stored bits.
    always_comb begin
        case (reg_sel)
            mpe_pkg::REG_INNER_LEN: prdata = 32'(inner_len_reg);
            mpe_pkg::REG_OUT_COLS:  prdata = 32'(out_cols_reg);
            default:                prdata = '0;
        endcase
    end

    // A zero dimension acts as one, and a dimension above the limit as the limit.
    function automatic logic [mpe_pkg::DIM_W-1:0] clamp_dim(
        input logic [mpe_pkg::DIM_W-1:0] v
    );
        logic [mpe_pkg::DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = mpe_pkg::DIM_W'(1);
        end else if ({2'b00, v} > 7'(MAX_DIM)) begin
            r = mpe_pkg::DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    assign inner_dim = clamp_dim(inner_len_reg);
    assign cols_dim  = clamp_dim(out_cols_reg);

endmodule

/* design/mpe_ctrl.sv */
// ----------------------------------------------------------------------------
// mpe_ctrl: sequencing controller
// Accepts input words, steps the datapath through division, range check,
// multiply-accumulate and result hand-off for each query.
// ----------------------------------------------------------------------------
module mpe_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic [mpe_pkg::OP_W-1:0]    op,
    output logic                        s_tready,
    input  mpe_pkg::ctrl_status_t       status,
    output mpe_pkg::ctrl_cmd_t          cmd
);

    mpe_pkg::state_t state_reg, state_next;
    logic            accept;

    assign s_tready = (state_reg == mpe_pkg::ST_IDLE);
    assign accept   = s_tvalid & s_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mpe_pkg::ST_IDLE: begin
                if (accept && op == mpe_pkg::OP_QUERY) state_next = mpe_pkg::ST_DIVIDE;
            end
            mpe_pkg::ST_DIVIDE: begin
                if (status.div_last) state_next = mpe_pkg::ST_BASE;
            end
            mpe_pkg::ST_BASE: begin
                state_next = mpe_pkg::ST_TEST;
            end
            mpe_pkg::ST_TEST: begin
                state_next = status.range_err ? mpe_pkg::ST_DRAIN : mpe_pkg::ST_MAC;
            end
            mpe_pkg::ST_MAC: begin
                if (status.issue_last) state_next = mpe_pkg::ST_DRAIN;
            end
            mpe_pkg::ST_DRAIN: begin
                if (!status.pipe_busy && status.out_free) state_next = mpe_pkg::ST_IDLE;
            end
            default: state_next = mpe_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mpe_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath commands.
    always_comb begin
        cmd = '0;
        case (state_reg)
            mpe_pkg::ST_IDLE: begin
                cmd.write_left  = accept && (op == mpe_pkg::OP_WRITE_LEFT);
                cmd.write_right = accept && (op == mpe_pkg::OP_WRITE_RIGHT);
                cmd.start       = accept && (op == mpe_pkg::OP_QUERY);
            end
            mpe_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
            mpe_pkg::ST_BASE:   cmd.base     = 1'b1;
            mpe_pkg::ST_TEST:   cmd.test     = 1'b1;
            mpe_pkg::ST_MAC:    cmd.issue    = 1'b1;
            mpe_pkg::ST_DRAIN:  cmd.load_out = !status.pipe_busy && status.out_free;
            default: ;
        endcase
    end

endmodule

/* design/mpe_datapath.sv */
// ----------------------------------------------------------------------------
// mpe_datapath: element stores, divider and multiply-accumulate
// Holds both matrix stores, splits the query index into row and column one
// bit per cycle, checks the address range and sums the products.
// ----------------------------------------------------------------------------
module mpe_datapath #(
    parameter int STORE_DEPTH = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mpe_pkg::ctrl_cmd_t            cmd,
    output mpe_pkg::ctrl_status_t         status,
    input  logic [mpe_pkg::IDX_W-1:0]     in_index,
    input  logic [mpe_pkg::DATA_W-1:0]    in_value,
    input  logic [mpe_pkg::DIM_W-1:0]     inner_dim,
    input  logic [mpe_pkg::DIM_W-1:0]     cols_dim,
    output logic [mpe_pkg::DATA_W-1:0]    out_product,
    output logic                          out_error,
    output logic                          out_valid,
    input  logic                          out_ready
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Element stores.
    logic [mpe_pkg::DATA_W-1:0] left_mem  [STORE_DEPTH];
    logic [mpe_pkg::DATA_W-1:0] right_mem [STORE_DEPTH];

    logic                       wr_in_range;
    logic [AW-1:0]              wr_addr;

    // Divider and address state.
    logic [mpe_pkg::IDX_W-1:0]  quot_reg;
    logic [mpe_pkg::DIM_W-1:0]  rem_reg;
    logic [mpe_pkg::DIVC_W-1:0] div_cnt_reg;
    logic [mpe_pkg::DIM_W-1:0]  tl_reg;
    logic [mpe_pkg::DIM_W-1:0]  kl_reg;
    logic [mpe_pkg::DIM_W:0]    trial;
    logic                       trial_ge;
    logic [mpe_pkg::BASE_W-1:0] row_base_reg;
    logic [mpe_pkg::CHK_W-1:0]  span_reg;
    logic [mpe_pkg::CHK_W-1:0]  row_end;
    logic                       err_reg;

    // Multiply-accumulate state.
    logic [AW-1:0]              left_ptr_reg;
    logic [AW-1:0]              right_ptr_reg;
    logic [mpe_pkg::DIM_W-1:0]  mac_cnt_reg;
    logic [mpe_pkg::DATA_W-1:0] left_q_reg;
    logic [mpe_pkg::DATA_W-1:0] right_q_reg;
    logic                       rd_valid_reg;
    logic [mpe_pkg::DATA_W-1:0] prod_reg;
    logic                       prod_valid_reg;
    logic [mpe_pkg::DATA_W-1:0] acc_reg;

    // Output register.
    logic [mpe_pkg::DATA_W-1:0] out_product_reg;
    logic                       out_error_reg;
    logic                       out_valid_reg;

    // Writes beyond the store depth are dropped.
    assign wr_in_range = {5'b00000, in_index} < 13'(STORE_DEPTH);
    assign wr_addr     = AW'(in_index);

    always_ff @(posedge aclk) begin
        if (cmd.write_left && wr_in_range) begin
            left_mem[wr_addr] <= in_value;
        end
        if (cmd.write_right && wr_in_range) begin
            right_mem[wr_addr] <= in_value;
        end
        left_q_reg  <= left_mem[left_ptr_reg];
        right_q_reg <= right_mem[right_ptr_reg];
    end

    // One restoring division step: shift in the next index bit.
    assign trial    = {rem_reg, quot_reg[mpe_pkg::IDX_W-1]};
    assign trial_ge = trial >= {1'b0, kl_reg};

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            quot_reg    <= in_index;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
            tl_reg      <= inner_dim;
            kl_reg      <= cols_dim;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (trial_ge) begin
                rem_reg  <= mpe_pkg::DIM_W'(trial - {1'b0, kl_reg});
                quot_reg <= {quot_reg[mpe_pkg::IDX_W-2:0], 1'b1};
            end else begin
                rem_reg  <= trial[mpe_pkg::DIM_W-1:0];
                quot_reg <= {quot_reg[mpe_pkg::IDX_W-2:0], 1'b0};
            end
        end
    end

    // Row base and highest right-store address of the query.
    always_ff @(posedge aclk) begin
        if (cmd.base) begin
            row_base_reg <= quot_reg * tl_reg;
            span_reg     <= mpe_pkg::CHK_W'(tl_reg - 1'b1) * mpe_pkg::CHK_W'(kl_reg)
                          + mpe_pkg::CHK_W'(rem_reg);
        end
    end

    assign row_end = mpe_pkg::CHK_W'(row_base_reg) + mpe_pkg::CHK_W'(tl_reg);

    // Read pointers walk along the left row and down the right column.
    always_ff @(posedge aclk) begin
        if (cmd.test) begin
            err_reg       <= status.range_err;
            left_ptr_reg  <= AW'(row_base_reg);
            right_ptr_reg <= AW'(rem_reg);
            mac_cnt_reg   <= '0;
        end else if (cmd.issue) begin
            left_ptr_reg  <= left_ptr_reg + 1'b1;
            right_ptr_reg <= right_ptr_reg + AW'(kl_reg);
            mac_cnt_reg   <= mac_cnt_reg + 1'b1;
        end
    end

    // Product and accumulate stages, both wrapping to 32 bits.
    always_ff @(posedge aclk) begin
        prod_reg <= left_q_reg * right_q_reg;
        if (cmd.test) begin
            acc_reg <= '0;
        end else if (prod_valid_reg) begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg   <= cmd.issue;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    // Result word register; it holds until the consumer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_product_reg <= acc_reg;
            out_error_reg   <= err_reg;
        end
    end

    assign out_product = out_product_reg;
    assign out_error   = out_error_reg;
    assign out_valid   = out_valid_reg;

    function automatic logic mpe_cnt_last(
        input logic [mpe_pkg::DIM_W-1:0] cnt,
        input logic [mpe_pkg::DIM_W-1:0] len
    );
        return cnt == (len - 1'b1);
    endfunction

    // Status back to the controller. The query fails when either store would
    // be read past its end.
    always_comb begin
        status.div_last   = (div_cnt_reg == mpe_pkg::DIVC_W'(mpe_pkg::IDX_W - 1));
        status.range_err  = (row_end > mpe_pkg::CHK_W'(STORE_DEPTH))
                         || (span_reg >= mpe_pkg::CHK_W'(STORE_DEPTH));
        status.issue_last = (mpe_cnt_last(mac_cnt_reg, tl_reg));
        status.pipe_busy  = rd_valid_reg | prod_valid_reg;
        status.out_free   = !out_valid_reg || out_ready;
    end

endmodule

/* design/matrix_product_element.sv */
// ----------------------------------------------------------------------------
// matrix_product_element: lazy integer matrix product element
// Write words load the left and right element stores one per cycle when idle;
// a query word returns one element of the product, wrapped to 32 bits.
// ----------------------------------------------------------------------------
// Writes may follow back to back. A query steps through the divider, the row base
// and range test, one store read and multiply-accumulate per inner element
// (clamped inner_len), then drains the pipeline and loads the result word once the
// result register is free; no new word is taken until the query is done.
// Out-of-range queries skip the accumulate loop.
// Reset (synchronous, active low) sets both dimensions to 16; stores are not cleared.
module matrix_product_element #(
    parameter int MAX_DIM     = 16,
    parameter int STORE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] index, [39:8] value
    input  logic [1:0]  s_tuser,   // [1:0] operation
    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] product
    output logic        m_tuser,   // [0] index_error
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [mpe_pkg::DIM_W-1:0] inner_dim;
    logic [mpe_pkg::DIM_W-1:0] cols_dim;
    mpe_pkg::ctrl_cmd_t        cmd;
    mpe_pkg::ctrl_status_t     status;

    mpe_regs #(
        .MAX_DIM (MAX_DIM)
    ) u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .inner_dim (inner_dim),
        .cols_dim  (cols_dim)
    );

    mpe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .op       (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mpe_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_index    (s_tdata[7:0]),
        .in_value    (s_tdata[39:8]),
        .inner_dim   (inner_dim),
        .cols_dim    (cols_dim),
        .out_product (m_tdata),
        .out_error   (m_tuser),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready)
    );

endmodule

/* verif/matrix_product_element_checker.sv */
// ----------------------------------------------------------------------------
// matrix_product_element_checker: result checker for the product element
// Watches the input, result and configuration channels of the block. It keeps
// its own copy of both element stores and both size registers, works out the
// product word for every accepted query, and compares each result word
// against the oldest one still waiting.
// ----------------------------------------------------------------------------
module matrix_product_element_checker #(
    parameter int MAX_DIM     = 16,
    parameter int STORE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] index, [39:8] value
    input  logic [1:0]  s_tuser,   // [1:0] operation
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] product
    input  logic        m_tuser,   // [0] index_error
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [mpe_pkg::DATA_W-1:0] product;
        logic                       index_error;
    } product_word_t;

    logic [mpe_pkg::DATA_W-1:0] left_mem  [STORE_DEPTH];
    logic [mpe_pkg::DATA_W-1:0] right_mem [STORE_DEPTH];
    logic [mpe_pkg::DIM_W-1:0]  inner_len_q = mpe_pkg::DIM_RESET;
    logic [mpe_pkg::DIM_W-1:0]  out_cols_q  = mpe_pkg::DIM_RESET;
    product_word_t              product_queue [$];
    int                         mismatches = 0;

    // A size of zero behaves as one, and anything above MAX_DIM as MAX_DIM.
    function automatic int clamp_dim(input logic [mpe_pkg::DIM_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // Dot product of the addressed left row and right column, wrapped to 32 bits.
    function automatic product_word_t compute_product(
        input logic [mpe_pkg::IDX_W-1:0] idx
    );
        int                         tl;
        int                         kl;
        int                         row_base;
        int                         col;
        logic [mpe_pkg::DATA_W-1:0] acc;
        product_word_t              res;
        tl       = clamp_dim(inner_len_q);
        kl       = clamp_dim(out_cols_q);
        row_base = (int'(idx) / kl) * tl;
        col      = int'(idx) % kl;
        res.index_error = (row_base + tl > STORE_DEPTH) ||
                          ((tl - 1) * kl + col >= STORE_DEPTH);
        acc = '0;
        if (!res.index_error) begin
            for (int n = 0; n < tl; n++) begin
                acc = acc + left_mem[row_base + n] * right_mem[n * kl + col];
            end
        end
        res.product = acc;
        return res;
    endfunction

    initial begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            left_mem[i]  = '0;
            right_mem[i] = '0;
        end
    end

    // Everything is sampled at the rising edge, where the block's registers
    // and the stimulus both still hold their pre-edge values.
    always @(posedge aclk) begin
        product_word_t got;
        product_word_t want;
        if (!aresetn) begin
            inner_len_q = mpe_pkg::DIM_RESET;
            out_cols_q  = mpe_pkg::DIM_RESET;
            product_queue.delete();
        end else begin
            // Result word against the oldest waiting expectation.
            if (m_tvalid && m_tready) begin
                got.product     = m_tdata;
                got.index_error = m_tuser;
                if (product_queue.size() == 0) begin
                    $error("Result word with no query waiting: product %h, index_error %b",
                           got.product, got.index_error);
                    mismatches++;
                end else begin
                    want = product_queue.pop_front();
                    if (got.product !== want.product) begin
                        $error("product: expected %h, actual %h", want.product, got.product);
                        mismatches++;
                    end
                    if (got.index_error !== want.index_error) begin
                        $error("index_error: expected %b, actual %b",
                               want.index_error, got.index_error);
                        mismatches++;
                    end
                end
            end

            // Input word: element writes update the stores, queries queue a result.
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    mpe_pkg::OP_WRITE_LEFT: begin
                        if (int'(s_tdata[mpe_pkg::IDX_W-1:0]) < STORE_DEPTH)
                            left_mem[s_tdata[mpe_pkg::IDX_W-1:0]] =
                                s_tdata[mpe_pkg::IDX_W +: mpe_pkg::DATA_W];
                    end
                    mpe_pkg::OP_WRITE_RIGHT: begin
                        if (int'(s_tdata[mpe_pkg::IDX_W-1:0]) < STORE_DEPTH)
                            right_mem[s_tdata[mpe_pkg::IDX_W-1:0]] =
                                s_tdata[mpe_pkg::IDX_W +: mpe_pkg::DATA_W];
                    end
                    mpe_pkg::OP_QUERY: begin
                        product_queue.push_back(
                            compute_product(s_tdata[mpe_pkg::IDX_W-1:0]));
                    end
                    default: begin
                        // The unused code changes nothing.
                    end
                endcase
            end

            // Register writes; the register keeps the low five bits.
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == mpe_pkg::REG_INNER_LEN) begin
                    inner_len_q = pwdata[mpe_pkg::DIM_W-1:0];
                end else begin
                    out_cols_q = pwdata[mpe_pkg::DIM_W-1:0];
                end
            end
        end
        fail_count    <= mismatches;
        pending_count <= product_queue.size();
    end

endmodule

/* verif/matrix_product_element_tb.sv */
// ----------------------------------------------------------------------------
// matrix_product_element_tb: regression for the matrix product element
// Loads element stores and asks for product elements over a range of matrix
// sizes, including zero and over-range register values. Before each query the
// elements it reads are written, so no store entry is read before it is set.
// Both channels stall at random; a checker beside the block does the compare.
// ----------------------------------------------------------------------------
module matrix_product_element_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM       = 16;
    localparam int STORE_DEPTH   = 256;
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 400_000;
    localparam int PHASE_COUNT   = 10;
    localparam int FIXED_PHASES  = 8;
    localparam int PHASE_ITEMS   = 70;
    localparam int IDLE_PERCENT  = 35;
    localparam int QUIET_PHASE   = 6;
    localparam logic [mpe_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending_count;
    int cycle_count    = 0;
    int writes_sent    = 0;
    int queries_sent   = 0;
    int range_queries  = 0;
    int settings_used  = 1;

    bit                        idling = 1'b1;
    bit                        left_written  [STORE_DEPTH];
    bit                        right_written [STORE_DEPTH];
    logic [mpe_pkg::DIM_W-1:0] inner_setting = mpe_pkg::DIM_RESET;
    logic [mpe_pkg::DIM_W-1:0] out_setting   = mpe_pkg::DIM_RESET;

    // Fixed size settings: smallest, zero, all ones, tall, wide, over-range, odd.
    logic [mpe_pkg::DIM_W-1:0] phase_inner [FIXED_PHASES] = '{5'd1, 5'd0, 5'd31, 5'd16,
                                                              5'd1, 5'd17, 5'd4, 5'd3};
    logic [mpe_pkg::DIM_W-1:0] phase_out   [FIXED_PHASES] = '{5'd1, 5'd0, 5'd31, 5'd1,
                                                              5'd16, 5'd5, 5'd8, 5'd7};

    matrix_product_element #(
        .MAX_DIM     (MAX_DIM),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    matrix_product_element_checker #(
        .MAX_DIM     (MAX_DIM),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 100 MHz clock.
    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side back-pressure.
    always @(posedge aclk) begin
        m_tready <= idling ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
    end

    function automatic int clamp_dim(input logic [mpe_pkg::DIM_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // Element values lean toward the extremes that stress the wrap-around.
    function automatic logic [mpe_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return int'($urandom_range(16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    // Offer one word, with random gaps ahead of it, and hold it until taken.
    task automatic send_word(input logic [mpe_pkg::OP_W-1:0] op,
                             input logic [mpe_pkg::IDX_W-1:0] idx,
                             input logic [mpe_pkg::DATA_W-1:0] val);
        if (idling) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_element(input logic [mpe_pkg::OP_W-1:0] op,
                                 input logic [mpe_pkg::IDX_W-1:0] idx,
                                 input logic [mpe_pkg::DATA_W-1:0] val);
        send_word(op, idx, val);
        if (op == mpe_pkg::OP_WRITE_LEFT) begin
            left_written[idx] = 1'b1;
        end else begin
            right_written[idx] = 1'b1;
        end
        writes_sent++;
    endtask

    // A query first loads every element it will read that is still unset.
    task automatic query_element(input logic [mpe_pkg::IDX_W-1:0] idx);
        int                        tl;
        int                        kl;
        int                        row_base;
        int                        col;
        logic [mpe_pkg::IDX_W-1:0] addr;
        tl       = clamp_dim(inner_setting);
        kl       = clamp_dim(out_setting);
        row_base = (int'(idx) / kl) * tl;
        col      = int'(idx) % kl;
        if (row_base + tl > STORE_DEPTH || (tl - 1) * kl + col >= STORE_DEPTH) begin
            range_queries++;
        end else begin
            for (int n = 0; n < tl; n++) begin
                addr = mpe_pkg::IDX_W'(row_base + n);
                if (!left_written[addr]) begin
                    write_element(mpe_pkg::OP_WRITE_LEFT, addr, pick_value());
                end
                addr = mpe_pkg::IDX_W'(n * kl + col);
                if (!right_written[addr]) begin
                    write_element(mpe_pkg::OP_WRITE_RIGHT, addr, pick_value());
                end
            end
        end
        // The value field of a query carries noise that must be ignored.
        send_word(mpe_pkg::OP_QUERY, idx, $urandom);
        queries_sent++;
    endtask

    // Drop valid, wait for every result, then let any trailing writes finish.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write (setup, then access phase) with junk in the unused upper bits.
    task automatic write_reg(input logic sel, input logic [mpe_pkg::DIM_W-1:0] dim);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {27'($urandom), dim};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        if (sel == mpe_pkg::REG_INNER_LEN) begin
            inner_setting = dim;
        end else begin
            out_setting = dim;
        end
    endtask

    // Random mix of writes, queries and unused-code words; most queries land inside the product.
    task automatic random_items(input int count);
        int done;
        int pick;
        int reach;
        done  = 0;
        reach = (STORE_DEPTH / clamp_dim(inner_setting)) * clamp_dim(out_setting) - 1;
        if (reach > 255) reach = 255;
        while (done < count) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                send_word(OP_UNUSED, mpe_pkg::IDX_W'($urandom_range(255)), $urandom);
            end else begin
                if (pick < 30) begin
                    write_element(mpe_pkg::OP_WRITE_LEFT,
                                  mpe_pkg::IDX_W'($urandom_range(255)), pick_value());
                end else if (pick < 55) begin
                    write_element(mpe_pkg::OP_WRITE_RIGHT,
                                  mpe_pkg::IDX_W'($urandom_range(255)), pick_value());
                end else if (pick < 90) begin
                    query_element(mpe_pkg::IDX_W'($urandom_range(reach)));
                end else begin
                    query_element(mpe_pkg::IDX_W'($urandom_range(255)));
                end
                done++;
            end
        end
    endtask

    initial begin
        logic [mpe_pkg::DIM_W-1:0] dim_inner;
        logic [mpe_pkg::DIM_W-1:0] dim_out;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words at the reset sizes: extreme values at both store ends,
        // the unused code over a loaded entry, corner product elements.
        write_element(mpe_pkg::OP_WRITE_LEFT, 8'h00, 32'h7FFF_FFFF);
        write_element(mpe_pkg::OP_WRITE_LEFT, 8'hFF, 32'h8000_0000);
        write_element(mpe_pkg::OP_WRITE_RIGHT, 8'h00, 32'h8000_0000);
        write_element(mpe_pkg::OP_WRITE_RIGHT, 8'hFF, 32'hFFFF_FFFF);
        send_word(OP_UNUSED, 8'h00, 32'hFFFF_FFFF);
        query_element(8'h00);
        query_element(8'hFF);
        query_element(8'd17);
        write_element(mpe_pkg::OP_WRITE_RIGHT, 8'h00, 32'h0000_0000);
        query_element(8'h00);
        write_element(mpe_pkg::OP_WRITE_LEFT, 8'hF0, 32'h8000_0000);
        query_element(8'hF0);

        // Size settings, each followed by a random stretch.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p < FIXED_PHASES) begin
                dim_inner = phase_inner[p];
                dim_out   = phase_out[p];
            end else begin
                dim_inner = mpe_pkg::DIM_W'($urandom_range(31));
                dim_out   = mpe_pkg::DIM_W'($urandom_range(31));
            end
            settle();
            write_reg(mpe_pkg::REG_INNER_LEN, dim_inner);
            write_reg(mpe_pkg::REG_OUT_COLS, dim_out);
            settings_used++;
            idling <= (p != QUIET_PHASE);
            random_items(PHASE_ITEMS);
        end
        settle();

        $display("Covered %0d element writes and %0d product queries (%0d out of range)",
                 writes_sent, queries_sent, range_queries);
        $display("over %0d size settings, with stalls on both channels and one stall-free phase.",
                 settings_used);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
